### hdl/nbg_pkg.sv
// nbg_pkg: shared widths, constants and the greedy digit helper for the note breakdown core
// used by nbg_div50k and note_breakdown_greedy_core; no dependencies
package nbg_pkg;

  localparam int AmountW = 31;
  localparam int Q50kW   = 16;
  localparam int RestW   = 16;

  // a / 50000 == (a >> 4) / 3125; reciprocal of 3125 scaled by 2^40
  localparam int                 RecipShift = 40;
  localparam int                 RecipW     = 29;
  localparam logic [RecipW-1:0]  Recip3125  = 29'd351843720;
  localparam int                 ScaledW    = AmountW - 4;
  localparam int                 ProdW      = ScaledW + RecipW;

  localparam logic [RestW-1:0] Denom50000 = 16'd50000;
  localparam logic [RestW-1:0] Denom20000 = 16'd20000;
  localparam logic [RestW-1:0] Denom10000 = 16'd10000;
  localparam logic [RestW-1:0] Denom5000  = 16'd5000;
  localparam logic [RestW-1:0] Denom2000  = 16'd2000;
  localparam logic [RestW-1:0] Denom1000  = 16'd1000;
  localparam logic [RestW-1:0] Denom500   = 16'd500;
  localparam logic [RestW-1:0] Denom200   = 16'd200;
  localparam logic [RestW-1:0] Denom100   = 16'd100;
  localparam logic [RestW-1:0] Denom50    = 16'd50;

  typedef struct packed {
    logic [1:0]       cnt;
    logic [RestW-1:0] rem;
  } digit_t;

  // one greedy step where the quotient is known to stay below three
  function automatic digit_t greedy_digit(input logic [RestW-1:0] rest,
                                          input logic [RestW-1:0] denom);
    digit_t          res;
    logic [RestW:0]  twice;
    twice = {denom, 1'b0};
    if ({1'b0, rest} >= twice) begin
      res.cnt = 2'd2;
      res.rem = rest - twice[RestW-1:0];
    end else if (rest >= denom) begin
      res.cnt = 2'd1;
      res.rem = rest - denom;
    end else begin
      res.cnt = 2'd0;
      res.rem = rest;
    end
    return res;
  endfunction

endpackage

### hdl/note_breakdown_greedy_core.sv
// note_breakdown_greedy_core: top level, greedy split of an amount into ten fixed denominations
// depends on nbg_pkg and nbg_div50k
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  input   | in        | valid_i / ready_o  | amount_i (31b)
//  result  | out       | valid_o / ready_i  | count_50000_o .. count_50_o, leftover_o
//
// six register stages: three for the divide by 50000, then three small
// compare-subtract stages (20000/10000/5000, 2000/1000/500, 200/100/50)
// one beat enters per cycle, limited by nothing but ready_i
// each stage holds its beat while the next is full and stalled; an empty stage
// still takes a beat, so bubbles close up behind a stalled output
// reset clears only the stage valid bits; ready_o is an or-chain of stage enables
module note_breakdown_greedy_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [30:0] amount_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [15:0] count_50000_o,
  output logic [1:0]  count_20000_o,
  output logic        count_10000_o,
  output logic        count_5000_o,
  output logic [1:0]  count_2000_o,
  output logic        count_1000_o,
  output logic        count_500_o,
  output logic [1:0]  count_200_o,
  output logic        count_100_o,
  output logic        count_50_o,
  output logic [5:0]  leftover_o
);

  // divider front end
  logic                      div_valid, div_ready;
  logic [nbg_pkg::Q50kW-1:0] div_quot;
  logic [nbg_pkg::RestW-1:0] div_rem;

  nbg_div50k u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_i),
    .ready_o  (ready_o),
    .amount_i (amount_i),
    .valid_o  (div_valid),
    .ready_i  (div_ready),
    .quot_o   (div_quot),
    .rem_o    (div_rem)
  );

  // stage valids and enables
  logic s4_v_q, s5_v_q, s6_v_q;
  logic s4_en, s5_en, s6_en;

  assign s6_en     = !s6_v_q || ready_i;
  assign s5_en     = !s5_v_q || s6_en;
  assign s4_en     = !s4_v_q || s5_en;
  assign div_ready = s4_en;

  // stage 4 payload: 20000, 10000, 5000; remainder below 5000
  logic [15:0] s4_c50000_q;
  logic [1:0]  s4_c20000_q;
  logic        s4_c10000_q, s4_c5000_q;
  logic [12:0] s4_rest_q;

  // stage 5 payload: 2000, 1000, 500; remainder below 500
  logic [15:0] s5_c50000_q;
  logic [1:0]  s5_c20000_q;
  logic        s5_c10000_q, s5_c5000_q;
  logic [1:0]  s5_c2000_q;
  logic        s5_c1000_q, s5_c500_q;
  logic [8:0]  s5_rest_q;

  // stage 6 payload is the output register
  logic [15:0] s6_c50000_q;
  logic [1:0]  s6_c20000_q;
  logic        s6_c10000_q, s6_c5000_q;
  logic [1:0]  s6_c2000_q;
  logic        s6_c1000_q, s6_c500_q;
  logic [1:0]  s6_c200_q;
  logic        s6_c100_q, s6_c50_q;
  logic [5:0]  s6_left_q;

  nbg_pkg::digit_t d20000, d10000, d5000;
  nbg_pkg::digit_t d2000, d1000, d500;
  nbg_pkg::digit_t d200, d100, d50;

  // chained greedy steps, three per stage
  always_comb begin
    d20000 = nbg_pkg::greedy_digit(div_rem, nbg_pkg::Denom20000);
    d10000 = nbg_pkg::greedy_digit(d20000.rem, nbg_pkg::Denom10000);
    d5000  = nbg_pkg::greedy_digit(d10000.rem, nbg_pkg::Denom5000);

    d2000  = nbg_pkg::greedy_digit(16'(s4_rest_q), nbg_pkg::Denom2000);
    d1000  = nbg_pkg::greedy_digit(d2000.rem, nbg_pkg::Denom1000);
    d500   = nbg_pkg::greedy_digit(d1000.rem, nbg_pkg::Denom500);

    d200   = nbg_pkg::greedy_digit(16'(s5_rest_q), nbg_pkg::Denom200);
    d100   = nbg_pkg::greedy_digit(d200.rem, nbg_pkg::Denom100);
    d50    = nbg_pkg::greedy_digit(d100.rem, nbg_pkg::Denom50);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
    end else begin
      if (s4_en) s4_v_q <= div_valid;
      if (s5_en) s5_v_q <= s4_v_q;
      if (s6_en) s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_en) begin
      s4_c50000_q <= div_quot;
      s4_c20000_q <= d20000.cnt;
      s4_c10000_q <= d10000.cnt[0];
      s4_c5000_q  <= d5000.cnt[0];
      s4_rest_q   <= d5000.rem[12:0];
    end
    if (s5_en) begin
      s5_c50000_q <= s4_c50000_q;
      s5_c20000_q <= s4_c20000_q;
      s5_c10000_q <= s4_c10000_q;
      s5_c5000_q  <= s4_c5000_q;
      s5_c2000_q  <= d2000.cnt;
      s5_c1000_q  <= d1000.cnt[0];
      s5_c500_q   <= d500.cnt[0];
      s5_rest_q   <= d500.rem[8:0];
    end
    if (s6_en) begin
      s6_c50000_q <= s5_c50000_q;
      s6_c20000_q <= s5_c20000_q;
      s6_c10000_q <= s5_c10000_q;
      s6_c5000_q  <= s5_c5000_q;
      s6_c2000_q  <= s5_c2000_q;
      s6_c1000_q  <= s5_c1000_q;
      s6_c500_q   <= s5_c500_q;
      s6_c200_q   <= d200.cnt;
      s6_c100_q   <= d100.cnt[0];
      s6_c50_q    <= d50.cnt[0];
      s6_left_q   <= d50.rem[5:0];
    end
  end

  assign valid_o       = s6_v_q;
  assign count_50000_o = s6_c50000_q;
  assign count_20000_o = s6_c20000_q;
  assign count_10000_o = s6_c10000_q;
  assign count_5000_o  = s6_c5000_q;
  assign count_2000_o  = s6_c2000_q;
  assign count_1000_o  = s6_c1000_q;
  assign count_500_o   = s6_c500_q;
  assign count_200_o   = s6_c200_q;
  assign count_100_o   = s6_c100_q;
  assign count_50_o    = s6_c50_q;
  assign leftover_o    = s6_left_q;

  // remainders shrink below each stage's smallest denomination
  a_s4_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_v_q |-> (s4_rest_q < 13'd5000))
    else $error("core: stage 4 remainder out of range");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (leftover_o < 6'd50 && count_20000_o != 2'd3 &&
                 count_2000_o != 2'd3 && count_200_o != 2'd3))
    else $error("core: result field out of range");

  a_s5_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s5_v_q && !s5_en) |=> (s5_v_q && $stable(s5_rest_q) && $stable(s5_c50000_q)))
    else $error("core: stalled stage 5 changed");

endmodule

### hdl/nbg_div50k.sv
// nbg_div50k: three-stage divide of the amount by 50000 (reciprocal multiply,
// back-multiply and subtract, one-step correction); depends on nbg_pkg
module nbg_div50k (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [nbg_pkg::AmountW-1:0] amount_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [nbg_pkg::Q50kW-1:0]   quot_o,
  output logic [nbg_pkg::RestW-1:0]   rem_o
);

  logic s1_v_q, s2_v_q, s3_v_q;
  logic s1_en, s2_en, s3_en;

  logic [nbg_pkg::AmountW-1:0] s1_amt_q;
  logic [nbg_pkg::Q50kW-1:0]   s1_qe_q;
  logic [nbg_pkg::Q50kW-1:0]   s2_q_q;
  logic [nbg_pkg::RestW:0]     s2_rem_q;
  logic [nbg_pkg::Q50kW-1:0]   s3_q_q;
  logic [nbg_pkg::RestW-1:0]   s3_rem_q;

  logic [nbg_pkg::ProdW-1:0]   prod;
  logic [nbg_pkg::AmountW:0]   back;
  logic [nbg_pkg::AmountW:0]   diff;
  logic [nbg_pkg::RestW:0]     rem_fix;

  assign s3_en   = !s3_v_q || ready_i;
  assign s2_en   = !s2_v_q || s3_en;
  assign s1_en   = !s1_v_q || s2_en;
  assign ready_o = s1_en;

  // estimate is the true quotient or one below it
  assign prod = nbg_pkg::ProdW'(amount_i[nbg_pkg::AmountW-1:4]) *
                nbg_pkg::ProdW'(nbg_pkg::Recip3125);

  assign back = (nbg_pkg::AmountW+1)'(s1_qe_q) *
                (nbg_pkg::AmountW+1)'(nbg_pkg::Denom50000);
  assign diff = {1'b0, s1_amt_q} - back;

  assign rem_fix = s2_rem_q - {1'b0, nbg_pkg::Denom50000};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_en) s1_v_q <= valid_i;
      if (s2_en) s2_v_q <= s1_v_q;
      if (s3_en) s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_amt_q <= amount_i;
      s1_qe_q  <= prod[nbg_pkg::RecipShift +: nbg_pkg::Q50kW];
    end
    if (s2_en) begin
      s2_q_q   <= s1_qe_q;
      s2_rem_q <= diff[nbg_pkg::RestW:0];
    end
    if (s3_en) begin
      if (s2_rem_q >= {1'b0, nbg_pkg::Denom50000}) begin
        s3_q_q   <= s2_q_q + 1'b1;
        s3_rem_q <= rem_fix[nbg_pkg::RestW-1:0];
      end else begin
        s3_q_q   <= s2_q_q;
        s3_rem_q <= s2_rem_q[nbg_pkg::RestW-1:0];
      end
    end
  end

  assign valid_o = s3_v_q;
  assign quot_o  = s3_q_q;
  assign rem_o   = s3_rem_q;

  // estimate is off by at most one divisor
  a_s2_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> (s2_rem_q < 17'd100000))
    else $error("div50k: raw remainder beyond two divisors");

  a_s3_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_v_q |-> (s3_rem_q < nbg_pkg::Denom50000))
    else $error("div50k: corrected remainder not below divisor");

  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && !s2_en) |=> ($stable(s2_q_q) && $stable(s2_rem_q) && s2_v_q))
    else $error("div50k: stalled stage changed");

endmodule
